### src/mfb_pkg.sv
// shared types and constants for the monochrome frame buffer raster core
package mfb_pkg;

    localparam int SCREEN_ROWS = 64;
    localparam int ROW_BYTES   = 16;
    localparam int STORE_DEPTH = SCREEN_ROWS * ROW_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(ROW_BYTES);
    localparam int ROW_W       = $clog2(SCREEN_ROWS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CMD_HLINE_SET  = 3'd0,
        CMD_RECT_CLEAR = 3'd1,
        CMD_VLINE_SET  = 3'd2,
        CMD_VLINE_CLR  = 3'd3,
        CMD_BLIT       = 3'd4,
        CMD_READ       = 3'd5,
        CMD_NOP6       = 3'd6,
        CMD_NOP7       = 3'd7
    } cmd_t;

    // decoded work item: a byte-wise operation over a box of bytes
    // every byte in rows row_first..row_last and byte columns col_first..col_last
    // gets data | mask when set_bits is set, else data & ~mask, with the mask picked per column
    typedef struct packed {
        logic              is_read;
        logic              is_blit;
        logic              set_bits;
        logic [ROW_W-1:0]  row_first;
        logic [ROW_W-1:0]  row_last;
        logic [COL_W-1:0]  col_first;
        logic [COL_W-1:0]  col_last;
        logic [7:0]        first_mask;
        logic [7:0]        last_mask;
        logic [7:0]        blit_hi;
    } work_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_RESULT
    } state_t;

endpackage

### src/mono_framebuffer_raster_ops_core.sv
// Top level of the monochrome frame buffer raster core.
// Each touched frame byte takes a read state then a write state in the back end memory port.
// A read passes the READ state, then gives its result in the RESULT state and holds it until taken.
// After reset the frame memory is cleared to zero byte by byte; commands queue (two deep) meanwhile.
module mono_framebuffer_raster_ops_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [6:0]  x_first,
    input  logic [6:0]  x_last,
    input  logic [5:0]  y_first,
    input  logic [5:0]  y_last,
    input  logic [7:0]  pattern,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);
    import mfb_pkg::*;

    work_t work;
    logic  work_valid;
    logic  work_take;

    // command intake and classification
    mfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid),
        .stall      (in_stall),
        .cmd        (cmd),
        .x_first    (x_first),
        .x_last     (x_last),
        .y_first    (y_first),
        .y_last     (y_last),
        .pattern    (pattern),
        .work_valid (work_valid),
        .work_take  (work_take),
        .work       (work)
    );

    // frame memory execution
    mfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_take  (work_take),
        .work       (work),
        .valid      (out_valid),
        .stall      (out_stall),
        .read_data  (read_data)
    );

endmodule

### src/mfb_front.sv
// front end: accepts commands, classifies them into byte box operations, queues them
module mfb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic [2:0]           cmd,
    input  logic [6:0]           x_first,
    input  logic [6:0]           x_last,
    input  logic [5:0]           y_first,
    input  logic [5:0]           y_last,
    input  logic [7:0]           pattern,
    output logic                 work_valid,
    input  logic                 work_take,
    output mfb_pkg::work_t       work
);
    import mfb_pkg::*;

    work_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    work_t              item;
    logic               keep;
    logic               push;
    logic               pop;
    logic [7:0]         lmask;
    logic [7:0]         rmask;
    logic [15:0]        shifted;

    // left edge mask keeps bits at or above x_first%8, right edge at or below x_last%8
    assign lmask   = 8'hFF << x_first[2:0];
    assign rmask   = 8'hFF >> (3'd7 - x_last[2:0]);
    assign shifted = {8'd0, pattern} << x_first[2:0];

    // classify the command
    always_comb
    begin
        item            = '0;
        keep            = 1'b0;
        item.row_first  = y_first;
        item.row_last   = y_first;
        item.col_first  = x_first[6:3];
        item.col_last   = x_first[6:3];
        item.blit_hi    = shifted[15:8];
        unique case (cmd_t'(cmd))
            CMD_HLINE_SET:
            begin
                keep          = (x_first <= x_last);
                item.set_bits = 1'b1;
                item.col_last = x_last[6:3];
                item.first_mask = lmask;
                item.last_mask  = rmask;
            end
            CMD_RECT_CLEAR:
            begin
                keep          = (x_first <= x_last) && (y_first <= y_last);
                item.row_last = y_last;
                item.col_last = x_last[6:3];
                item.first_mask = lmask;
                item.last_mask  = rmask;
            end
            CMD_VLINE_SET, CMD_VLINE_CLR:
            begin
                keep            = (y_first <= y_last);
                item.set_bits   = (cmd_t'(cmd) == CMD_VLINE_SET);
                item.row_last   = y_last;
                item.first_mask = 8'd1 << x_first[2:0];
                item.last_mask  = 8'd1 << x_first[2:0];
            end
            CMD_BLIT:
            begin
                keep            = 1'b1;
                item.is_blit    = 1'b1;
                item.set_bits   = 1'b1;
                item.col_last   = (x_first[6:3] == COL_W'(ROW_BYTES - 1)) ?
                                  x_first[6:3] : x_first[6:3] + 1'b1;
                item.first_mask = shifted[7:0];
                item.last_mask  = shifted[15:8];
            end
            CMD_READ:
            begin
                keep         = 1'b1;
                item.is_read = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign stall      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = valid && !stall && keep;
    assign pop        = work_take && (count_reg != '0);
    assign work_valid = (count_reg != '0);
    assign work       = queue_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

### src/mfb_back.sv
// back end: walks byte boxes with read-modify-write over the frame memory
module mfb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 work_valid,
    output logic                 work_take,
    input  mfb_pkg::work_t       work,
    output logic                 valid,
    input  logic                 stall,
    output logic [7:0]           read_data
);
    import mfb_pkg::*;

    logic [7:0]         mem [STORE_DEPTH];
    state_t             state_reg, state_next;
    work_t              cur_reg, cur_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [7:0]         rd_reg;
    logic [ADDR_W-1:0]  addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mask;
    logic [7:0]         new_byte;

    assign addr = {row_reg, col_reg};

    // pick mask for the current byte column
    always_comb
    begin
        if (cur_reg.is_blit)
        begin
            mask = (col_reg == cur_reg.col_first) ? cur_reg.first_mask : cur_reg.blit_hi;
        end
        else
        begin
            mask = 8'hFF;
            if (col_reg == cur_reg.col_first)
            begin
                mask = mask & cur_reg.first_mask;
            end
            if (col_reg == cur_reg.col_last)
            begin
                mask = mask & cur_reg.last_mask;
            end
        end
        new_byte = cur_reg.set_bits ? (rd_reg | mask) : (rd_reg & ~mask);
    end

    // frame memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[addr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        clr_next   = clr_reg;
        work_take  = 1'b0;
        valid      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = addr;
        mem_wdata  = new_byte;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    work_take  = 1'b1;
                    cur_next   = work;
                    row_next   = work.row_first;
                    col_next   = work.col_first;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = cur_reg.is_read ? ST_RESULT : ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (col_reg != cur_reg.col_last)
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_READ;
                end
                else if (row_reg != cur_reg.row_last)
                begin
                    col_next   = cur_reg.col_first;
                    row_next   = row_reg + 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                valid = 1'b1;
                if (!stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign read_data = rd_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // work item registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        row_reg <= row_next;
        col_reg <= col_next;
    end

endmodule

### src/mfb_checker.sv
// port-level checker for the frame buffer raster core, bound to the top level
module mfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data
);

    // a stalled result holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("stalled result changed");

    // a taken result is not repeated on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result repeated");

    // no result while reset is asserted
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result during reset");

    // the intake is open right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_stall)
        else $error("intake stalled after reset");

endmodule

bind mono_framebuffer_raster_ops_core mfb_checker u_mfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
);
